>>> design/tcse_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// tcse_pkg
// Shared types and constants for the telnet command stream engine.
// -----------------------------------------------------------------------------
package tcse_pkg;

    // Telnet command codes
    localparam logic [7:0] C_IAC   = 8'd255;
    localparam logic [7:0] C_DONT  = 8'd254;
    localparam logic [7:0] C_DO    = 8'd253;
    localparam logic [7:0] C_WONT  = 8'd252;
    localparam logic [7:0] C_WILL  = 8'd251;
    localparam logic [7:0] C_SB    = 8'd250;
    localparam logic [7:0] C_EL    = 8'd248;
    localparam logic [7:0] C_EC    = 8'd247;
    localparam logic [7:0] C_AYT   = 8'd246;
    localparam logic [7:0] C_IP    = 8'd244;
    localparam logic [7:0] C_BREAK = 8'd243;
    localparam logic [7:0] C_SE    = 8'd240;

    // Option codes
    localparam logic [7:0] OPT_BINARY = 8'd0;
    localparam logic [7:0] OPT_ECHO   = 8'd1;
    localparam logic [7:0] OPT_SGA    = 8'd3;

    // Characters
    localparam logic [7:0] CH_NUL  = 8'd0;
    localparam logic [7:0] CH_BELL = 8'd7;
    localparam logic [7:0] CH_LF   = 8'd10;
    localparam logic [7:0] CH_CR   = 8'd13;

    // Config register indexes (word address paddr[3:2])
    localparam logic [1:0] REG_ERASE = 2'd0;
    localparam logic [1:0] REG_KILL  = 2'd1;
    localparam logic [1:0] REG_INTR  = 2'd2;

    localparam int          ADDR_W      = 4;
    localparam int          DATA_W      = 32;
    localparam logic [7:0]  ERASE_RESET = 8'd35;
    localparam logic [7:0]  KILL_RESET  = 8'd64;
    localparam logic [7:0]  INTR_RESET  = 8'd127;

    typedef struct packed {
        logic [7:0] erase_char;
        logic [7:0] kill_char;
        logic [7:0] interrupt_char;
    } tcse_cfg_t;

    // Results of one transaction: up to three bytes, one destination, mode flags
    typedef struct packed {
        logic [1:0] count;
        logic [7:0] byte0;
        logic [7:0] byte1;
        logic [7:0] byte2;
        logic       net;
        logic       raw;
        logic       echo;
        logic       crmod;
    } tcse_emit_t;

endpackage
`default_nettype wire

>>> design/tcse_cfg_regs.sv
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// tcse_cfg_regs
// APB register file: erase, kill and interrupt characters.
// -----------------------------------------------------------------------------
module tcse_cfg_regs (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [tcse_pkg::ADDR_W-1:0]   paddr,
    input  wire logic [tcse_pkg::DATA_W-1:0]   pwdata,
    output logic      [tcse_pkg::DATA_W-1:0]   prdata,
    output logic                               pready,
    output tcse_pkg::tcse_cfg_t                cfg
);

    logic [7:0] erase_reg;
    logic [7:0] kill_reg;
    logic [7:0] intr_reg;
    logic       wr_en;
    logic [1:0] reg_idx;

    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[3:2];
    assign pready  = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            erase_reg <= tcse_pkg::ERASE_RESET;
            kill_reg  <= tcse_pkg::KILL_RESET;
            intr_reg  <= tcse_pkg::INTR_RESET;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                tcse_pkg::REG_ERASE: erase_reg <= pwdata[7:0];
                tcse_pkg::REG_KILL:  kill_reg  <= pwdata[7:0];
                tcse_pkg::REG_INTR:  intr_reg  <= pwdata[7:0];
                default:             ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            tcse_pkg::REG_ERASE: prdata = {24'd0, erase_reg};
            tcse_pkg::REG_KILL:  prdata = {24'd0, kill_reg};
            tcse_pkg::REG_INTR:  prdata = {24'd0, intr_reg};
            default:             prdata = '0;
        endcase
    end

    assign cfg.erase_char     = erase_reg;
    assign cfg.kill_char      = kill_reg;
    assign cfg.interrupt_char = intr_reg;

endmodule
`default_nettype wire

>>> design/tcse_rx_fsm.sv
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// tcse_rx_fsm
// Telnet receive machine, option state and mode flags; decodes one byte.
// -----------------------------------------------------------------------------
module tcse_rx_fsm (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 step,
    input  wire logic                 kind,
    input  wire logic [7:0]           data_byte,
    input  tcse_pkg::tcse_cfg_t       cfg,
    output tcse_pkg::tcse_emit_t      emit
);

    localparam logic [3:0] ST_DATA   = 4'd0;
    localparam logic [3:0] ST_IAC    = 4'd1;
    localparam logic [3:0] ST_CR     = 4'd2;
    localparam logic [3:0] ST_SUB    = 4'd3;
    localparam logic [3:0] ST_SUBIAC = 4'd4;
    localparam logic [3:0] ST_WILL   = 4'd5;
    localparam logic [3:0] ST_WONT   = 4'd6;
    localparam logic [3:0] ST_DO     = 4'd7;
    localparam logic [3:0] ST_DONT   = 4'd8;

    // Only BINARY, ECHO and SGA can ever be set in either option table;
    // every other entry stays zero, so three bits per table suffice.
    logic [3:0] state_reg, state_next;
    logic       raw_reg, raw_next;
    logic       echo_reg, echo_next;
    logic       crmod_reg, crmod_next;
    logic       peer_bin_reg, peer_bin_next;
    logic       peer_echo_reg, peer_echo_next;
    logic       peer_sga_reg, peer_sga_next;
    logic       loc_bin_reg, loc_bin_next;
    logic       loc_echo_reg, loc_echo_next;
    logic       loc_sga_reg, loc_sga_next;

    logic       peer_cur;
    logic       loc_cur;
    logic [7:0] c;

    assign c = data_byte;

    always_comb
    begin
        if (c == tcse_pkg::OPT_BINARY)
        begin
            peer_cur = peer_bin_reg;
            loc_cur  = loc_bin_reg;
        end
        else if (c == tcse_pkg::OPT_ECHO)
        begin
            peer_cur = peer_echo_reg;
            loc_cur  = loc_echo_reg;
        end
        else if (c == tcse_pkg::OPT_SGA)
        begin
            peer_cur = peer_sga_reg;
            loc_cur  = loc_sga_reg;
        end
        else
        begin
            peer_cur = 1'b0;
            loc_cur  = 1'b0;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        raw_next       = raw_reg;
        echo_next      = echo_reg;
        crmod_next     = crmod_reg;
        peer_bin_next  = peer_bin_reg;
        peer_echo_next = peer_echo_reg;
        peer_sga_next  = peer_sga_reg;
        loc_bin_next   = loc_bin_reg;
        loc_echo_next  = loc_echo_reg;
        loc_sga_next   = loc_sga_reg;
        emit.count     = 2'd0;
        emit.byte0     = c;
        emit.byte1     = tcse_pkg::C_IAC;
        emit.byte2     = c;
        emit.net       = 1'b0;

        if (step)
        begin
            if (kind)
            begin
                // terminal side: IAC is doubled
                emit.net   = 1'b1;
                emit.count = (c == tcse_pkg::C_IAC) ? 2'd2 : 2'd1;
            end
            else
            begin
                case (state_reg)
                    ST_CR:
                    begin
                        if (c != tcse_pkg::CH_NUL && c != tcse_pkg::CH_LF)
                            emit.count = 2'd1;
                        state_next = ST_DATA;
                    end
                    ST_IAC:
                    begin
                        state_next = ST_DATA;
                        if (c == tcse_pkg::C_BREAK || c == tcse_pkg::C_IP)
                        begin
                            emit.count = 2'd1;
                            emit.byte0 = raw_reg ? 8'd0 : cfg.interrupt_char;
                        end
                        else if (c == tcse_pkg::C_AYT)
                        begin
                            emit.count = 2'd1;
                            emit.byte0 = tcse_pkg::CH_BELL;
                        end
                        else if (c == tcse_pkg::C_EC)
                        begin
                            emit.count = 2'd1;
                            emit.byte0 = cfg.erase_char;
                        end
                        else if (c == tcse_pkg::C_EL)
                        begin
                            emit.count = 2'd1;
                            emit.byte0 = cfg.kill_char;
                        end
                        else if (c == tcse_pkg::C_SB)
                            state_next = ST_SUB;
                        else if (c == tcse_pkg::C_WILL)
                            state_next = ST_WILL;
                        else if (c == tcse_pkg::C_WONT)
                            state_next = ST_WONT;
                        else if (c == tcse_pkg::C_DO)
                            state_next = ST_DO;
                        else if (c == tcse_pkg::C_DONT)
                            state_next = ST_DONT;
                        else if (c == tcse_pkg::C_IAC)
                            emit.count = 2'd1;
                    end
                    ST_SUB:
                    begin
                        if (c == tcse_pkg::C_IAC)
                            state_next = ST_SUBIAC;
                    end
                    ST_SUBIAC:
                    begin
                        state_next = (c == tcse_pkg::C_SE) ? ST_DATA : ST_SUB;
                    end
                    ST_WILL:
                    begin
                        state_next = ST_DATA;
                        if (!peer_cur)
                        begin
                            emit.count = 2'd3;
                            emit.net   = 1'b1;
                            emit.byte0 = tcse_pkg::C_IAC;
                            emit.byte1 = tcse_pkg::C_DO;
                            if (c == tcse_pkg::OPT_BINARY)
                            begin
                                raw_next      = 1'b1;
                                peer_bin_next = 1'b1;
                            end
                            else if (c == tcse_pkg::OPT_ECHO)
                            begin
                                echo_next      = 1'b0;
                                crmod_next     = 1'b0;
                                peer_echo_next = 1'b1;
                            end
                            else if (c == tcse_pkg::OPT_SGA)
                                peer_sga_next = 1'b1;
                            else
                                emit.byte1 = tcse_pkg::C_DONT;
                        end
                    end
                    ST_WONT:
                    begin
                        state_next = ST_DATA;
                        // peer_cur is only ever set for known options
                        if (peer_cur)
                        begin
                            emit.count = 2'd3;
                            emit.net   = 1'b1;
                            emit.byte0 = tcse_pkg::C_IAC;
                            emit.byte1 = tcse_pkg::C_DONT;
                            if (c == tcse_pkg::OPT_ECHO)
                            begin
                                echo_next      = 1'b1;
                                crmod_next     = 1'b1;
                                peer_echo_next = 1'b0;
                            end
                            else if (c == tcse_pkg::OPT_BINARY)
                            begin
                                raw_next      = 1'b0;
                                peer_bin_next = 1'b0;
                            end
                            else
                                peer_sga_next = 1'b0;
                        end
                    end
                    ST_DO:
                    begin
                        state_next = ST_DATA;
                        if (!loc_cur)
                        begin
                            emit.count = 2'd3;
                            emit.net   = 1'b1;
                            emit.byte0 = tcse_pkg::C_IAC;
                            emit.byte1 = tcse_pkg::C_WILL;
                            if (c == tcse_pkg::OPT_ECHO)
                            begin
                                echo_next     = 1'b1;
                                crmod_next    = 1'b1;
                                loc_echo_next = 1'b1;
                            end
                            else if (c == tcse_pkg::OPT_BINARY)
                            begin
                                raw_next     = 1'b1;
                                loc_bin_next = 1'b1;
                            end
                            else if (c == tcse_pkg::OPT_SGA)
                                loc_sga_next = 1'b1;
                            else
                                emit.byte1 = tcse_pkg::C_WONT;
                        end
                    end
                    ST_DONT:
                    begin
                        state_next = ST_DATA;
                        if (loc_cur)
                        begin
                            emit.count = 2'd3;
                            emit.net   = 1'b1;
                            emit.byte0 = tcse_pkg::C_IAC;
                            emit.byte1 = tcse_pkg::C_WONT;
                            if (c == tcse_pkg::OPT_BINARY)
                                loc_bin_next = 1'b0;
                            else if (c == tcse_pkg::OPT_ECHO)
                                loc_echo_next = 1'b0;
                            else
                                loc_sga_next = 1'b0;
                        end
                    end
                    default:
                    begin
                        // data state (unused codes behave the same)
                        if (c == tcse_pkg::C_IAC)
                            state_next = ST_IAC;
                        else
                        begin
                            emit.count = 2'd1;
                            if (!loc_bin_reg && c == tcse_pkg::CH_CR)
                                state_next = ST_CR;
                            else
                                state_next = ST_DATA;
                        end
                    end
                endcase
            end
        end

        emit.raw   = raw_next;
        emit.echo  = echo_next;
        emit.crmod = crmod_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_DATA;
            raw_reg       <= 1'b0;
            echo_reg      <= 1'b1;
            crmod_reg     <= 1'b1;
            peer_bin_reg  <= 1'b0;
            peer_echo_reg <= 1'b0;
            peer_sga_reg  <= 1'b0;
            loc_bin_reg   <= 1'b0;
            loc_echo_reg  <= 1'b1;
            loc_sga_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            raw_reg       <= raw_next;
            echo_reg      <= echo_next;
            crmod_reg     <= crmod_next;
            peer_bin_reg  <= peer_bin_next;
            peer_echo_reg <= peer_echo_next;
            peer_sga_reg  <= peer_sga_next;
            loc_bin_reg   <= loc_bin_next;
            loc_echo_reg  <= loc_echo_next;
            loc_sga_reg   <= loc_sga_next;
        end
    end

endmodule
`default_nettype wire

>>> design/tcse_out_buf.sv
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// tcse_out_buf
// Result register: holds up to three bytes of one transaction, drains in order.
// -----------------------------------------------------------------------------
module tcse_out_buf (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 load,
    input  tcse_pkg::tcse_emit_t      emit,
    input  wire logic                 out_stall,
    output logic                      busy,
    output logic                      out_valid,
    output logic [7:0]                out_byte,
    output logic                      to_network,
    output logic                      last,
    output logic                      raw_mode,
    output logic                      echo_mode,
    output logic                      crlf_mode
);

    logic [1:0] cnt_reg;
    logic [7:0] b0_reg, b1_reg, b2_reg;
    logic       net_reg, raw_reg, echo_reg, crmod_reg;
    logic       take;

    assign out_valid  = (cnt_reg != 2'd0);
    assign take       = out_valid && !out_stall;
    // can load a new transaction only when the register is empty or its final byte leaves now
    assign busy       = (cnt_reg > 2'd1) || ((cnt_reg == 2'd1) && out_stall);
    assign out_byte   = b0_reg;
    assign to_network = net_reg;
    assign last       = (cnt_reg == 2'd1);
    assign raw_mode   = raw_reg;
    assign echo_mode  = echo_reg;
    assign crlf_mode  = crmod_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= 2'd0;
        else if (load)
            cnt_reg <= emit.count;
        else if (take)
            cnt_reg <= cnt_reg - 2'd1;
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            b0_reg    <= emit.byte0;
            b1_reg    <= emit.byte1;
            b2_reg    <= emit.byte2;
            net_reg   <= emit.net;
            raw_reg   <= emit.raw;
            echo_reg  <= emit.echo;
            crmod_reg <= emit.crmod;
        end
        else if (take)
        begin
            b0_reg <= b1_reg;
            b1_reg <= b2_reg;
        end
    end

endmodule
`default_nettype wire

>>> design/telnet_command_stream_engine_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// telnet_command_stream_engine_unit
// Telnet byte engine: IAC parsing, option negotiation, terminal byte escaping.
// -----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_stall, kind, data_byte) carries one byte per
//   transaction: kind 0 from the network, kind 1 from the terminal side.
//   Output channel (out_valid/out_stall) carries 0..3 result bytes per input
//   transaction, tagged with to_network, last and the mode flags after it.
//   A transaction that yields nothing produces no output transaction.
// Output timing: results are registered and appear in the cycle after the input is accepted.
// Throughput: one byte per cycle without out_stall if each byte yields
//   at most one result; a doubled IAC or three-byte option reply holds the
//   input as the single register drains one byte per cycle without out_stall.
// Stall: in_stall rises while the output register still holds bytes that
//   will not all leave in the current cycle; a new byte is taken in the same
//   cycle the final pending byte is taken downstream.
// Reset (rst_n, async low): receive machine to data state, option tables
//   cleared except local ECHO, raw off, echo and crmod on, output empty,
//   registers to erase '#', kill '@', interrupt DEL.
// Config: APB at 0x0 erase, 0x4 kill, 0x8 interrupt; write only when idle.
// -----------------------------------------------------------------------------
module telnet_command_stream_engine_unit (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    // input byte channel
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic                          kind,
    input  wire logic [7:0]                    data_byte,
    // result channel
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic [7:0]                         out_byte,
    output logic                               to_network,
    output logic                               last,
    output logic                               raw_mode,
    output logic                               echo_mode,
    output logic                               crlf_mode,
    // configuration
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [tcse_pkg::ADDR_W-1:0]   paddr,
    input  wire logic [tcse_pkg::DATA_W-1:0]   pwdata,
    output logic      [tcse_pkg::DATA_W-1:0]   prdata,
    output logic                               pready
);

    tcse_pkg::tcse_cfg_t  cfg;
    tcse_pkg::tcse_emit_t emit;
    logic                 busy;
    logic                 accept;

    assign in_stall = busy;
    assign accept   = in_valid && !busy;

    tcse_cfg_regs u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // decode and state update happen at the accepting edge
    tcse_rx_fsm u_rx (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (accept),
        .kind      (kind),
        .data_byte (data_byte),
        .cfg       (cfg),
        .emit      (emit)
    );

    tcse_out_buf u_out (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (accept),
        .emit       (emit),
        .out_stall  (out_stall),
        .busy       (busy),
        .out_valid  (out_valid),
        .out_byte   (out_byte),
        .to_network (to_network),
        .last       (last),
        .raw_mode   (raw_mode),
        .echo_mode  (echo_mode),
        .crlf_mode  (crlf_mode)
    );

endmodule
`default_nettype wire

>>> design/tcse_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// tcse_checker
// Port-level checks for the telnet command stream engine.
// -----------------------------------------------------------------------------
module tcse_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       in_stall,
    input wire logic       out_valid,
    input wire logic       out_stall,
    input wire logic [7:0] out_byte,
    input wire logic       to_network,
    input wire logic       last
);

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_byte) && $stable(last))
        else $error("stalled result changed");

    // input is only held off while results are pending
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid)
        else $error("input stalled with empty output");

    // a multi-byte transaction blocks the input until its last byte
    a_mid_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !last |-> in_stall)
        else $error("input accepted mid-transaction");

    // all bytes of one transaction go the same way
    a_same_dest: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && !last |=> out_valid && to_network == $past(to_network))
        else $error("destination changed within a transaction");

endmodule

bind telnet_command_stream_engine_unit tcse_checker u_tcse_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_stall   (in_stall),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_byte   (out_byte),
    .to_network (to_network),
    .last       (last)
);
`default_nettype wire
